[src/mqmm_pkg.sv]
// Shared types, constants and status codes for the multi-queue mailbox manager.
// No dependencies; used by every module of the block.
package mqmm_pkg;

  localparam int unsigned POOL_SLOTS    = 64;
  localparam int unsigned QUEUES        = 64;
  localparam int unsigned QUEUE_LIMIT   = 16;
  localparam int unsigned PAYLOAD_BYTES = 8;

  localparam int unsigned SW    = $clog2(POOL_SLOTS);
  localparam int unsigned QW    = $clog2(QUEUES);
  localparam int unsigned CNT_W = 5;
  localparam int unsigned FC_W  = $clog2(POOL_SLOTS + 1);

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RECV = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_PID     = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_QUEUE_FULL  = 3'd3,
    ST_NO_SLOT     = 3'd4,
    ST_WOULD_BLOCK = 3'd5,
    ST_EMPTY       = 3'd6,
    ST_RSVD        = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_RD_Q   = 2'd1,
    S_RD_S   = 2'd2,
    S_COMMIT = 2'd3
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic rd_q;    // beat accepted: latch request, read queue tables
    logic rd_s;    // read slot tables at the queue head
    logic commit;  // update state, load result register
  } ctrl_cmd_t;

endpackage

[src/mqmm_ctrl.sv]
// Request sequencer of the mailbox manager: handshakes and step commands.
// Depends on mqmm_pkg.
module mqmm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mqmm_pkg::ctrl_cmd_t  cmd_o
);

  mqmm_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             can_commit;

  assign can_commit = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mqmm_pkg::S_IDLE:   if (in_valid_i) state_d = mqmm_pkg::S_RD_Q;
      mqmm_pkg::S_RD_Q:   state_d = mqmm_pkg::S_RD_S;
      mqmm_pkg::S_RD_S:   state_d = mqmm_pkg::S_COMMIT;
      mqmm_pkg::S_COMMIT: if (can_commit) state_d = mqmm_pkg::S_IDLE;
      default:            state_d = mqmm_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      mqmm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.rd_q = in_valid_i;
      end
      mqmm_pkg::S_RD_Q:   cmd_o.rd_s = 1'b1;
      mqmm_pkg::S_RD_S:   ;
      mqmm_pkg::S_COMMIT: cmd_o.commit = can_commit;
      default:            ;
    endcase
  end

  // Result valid: set on commit, drop when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqmm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/mqmm_dp.sv]
// Datapath of the mailbox manager: slot pool, queue tables, free list, result.
// Depends on mqmm_pkg.
module mqmm_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mqmm_pkg::ctrl_cmd_t            cmd_i,
  input  logic                           cfg_we_i,
  input  logic [63:0]                    cfg_wdata_i,
  input  logic [1:0]                     action_i,
  input  logic [5:0]                     requester_i,
  input  logic [7:0]                     dest_i,
  input  logic [63:0]                    payload_i,
  input  logic [7:0]                     length_i,
  input  logic [7:0]                     max_len_i,
  output logic [2:0]                     status_o,
  output logic [63:0]                    data_o,
  output logic [3:0]                     xfer_len_o,
  output logic [5:0]                     source_o,
  output logic [4:0]                     pending_o,
  output logic [mqmm_pkg::FC_W-1:0]      free_cnt_o
);

  localparam int unsigned SW  = mqmm_pkg::SW;
  localparam int unsigned QW  = mqmm_pkg::QW;
  localparam int unsigned CW  = mqmm_pkg::CNT_W;
  localparam int unsigned FW  = mqmm_pkg::FC_W;
  localparam int unsigned NP  = mqmm_pkg::POOL_SLOTS;
  localparam int unsigned NQ  = mqmm_pkg::QUEUES;

  // Memories
  logic [SW-1:0] nxt_mem  [NP];
  logic [63:0]   pay_mem  [NP];
  logic [3:0]    len_mem  [NP];
  logic [5:0]    src_mem  [NP];
  logic [SW-1:0] head_mem [NQ];
  logic [SW-1:0] tail_mem [NQ];
  logic [CW-1:0] cnt_mem  [NQ];
  logic [NP-1:0] nxt_vld_q;
  logic [NQ-1:0] cnt_vld_q;

  logic [63:0]   live_q;
  logic [SW-1:0] free_head_q, free_head_d;
  logic [FW-1:0] free_cnt_q, free_cnt_d;

  // Request registers
  logic [1:0]    act_q;
  logic [5:0]    req_q;
  logic [7:0]    dst_q;
  logic [63:0]   pay_q;
  logic [7:0]    len_q;
  logic [7:0]    mlen_q;

  // Read data registers
  logic [CW-1:0] cnt_d_raw_q, cnt_r_raw_q;
  logic          cnt_d_v_q, cnt_r_v_q;
  logic [SW-1:0] head_r_q, tail_d_q;
  logic [SW-1:0] fnx_raw_q, fnx_addr_q;
  logic          fnx_v_q;
  logic [SW-1:0] snx_raw_q, snx_addr_q;
  logic          snx_v_q;
  logic [63:0]   s_pay_q;
  logic [3:0]    s_len_q;
  logic [5:0]    s_src_q;

  // Result registers
  logic [2:0]    status_q;
  logic [63:0]   data_q;
  logic [3:0]    copy_q;
  logic [5:0]    source_q;
  logic [4:0]    pending_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cfg_we_i) begin
      live_q <= cfg_wdata_i;
    end
  end

  // Latch request and read queue tables at the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_q) begin
      act_q       <= action_i;
      req_q       <= requester_i;
      dst_q       <= dest_i;
      pay_q       <= payload_i;
      len_q       <= length_i;
      mlen_q      <= max_len_i;
      cnt_d_raw_q <= cnt_mem[dest_i[QW-1:0]];
      cnt_d_v_q   <= cnt_vld_q[dest_i[QW-1:0]];
      cnt_r_raw_q <= cnt_mem[requester_i[QW-1:0]];
      cnt_r_v_q   <= cnt_vld_q[requester_i[QW-1:0]];
      head_r_q    <= head_mem[requester_i[QW-1:0]];
      tail_d_q    <= tail_mem[dest_i[QW-1:0]];
      fnx_raw_q   <= nxt_mem[free_head_q];
      fnx_v_q     <= nxt_vld_q[free_head_q];
      fnx_addr_q  <= free_head_q;
    end
  end

  // Read slot tables at the requester's queue head
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_s) begin
      s_pay_q    <= pay_mem[head_r_q];
      s_len_q    <= len_mem[head_r_q];
      s_src_q    <= src_mem[head_r_q];
      snx_raw_q  <= nxt_mem[head_r_q];
      snx_v_q    <= nxt_vld_q[head_r_q];
      snx_addr_q <= head_r_q;
    end
  end

  // Unwritten entries read as their reset value
  logic [CW-1:0] cnt_d, cnt_r;
  logic [SW-1:0] fnx, snx;
  assign cnt_d = cnt_d_v_q ? cnt_d_raw_q : '0;
  assign cnt_r = cnt_r_v_q ? cnt_r_raw_q : '0;
  assign fnx = fnx_v_q ? fnx_raw_q
             : ((fnx_addr_q == SW'(NP - 1)) ? '0 : fnx_addr_q + SW'(1));
  assign snx = snx_v_q ? snx_raw_q
             : ((snx_addr_q == SW'(NP - 1)) ? '0 : snx_addr_q + SW'(1));

  // Decision logic
  logic          dst_ok, req_ok, is_send, is_rdq;
  logic          send_ok, recv_ok, read_ok;
  logic [2:0]    st;
  logic [3:0]    copy;
  logic [63:0]   send_mask, rd_data;
  logic [4:0]    pend;

  assign dst_ok  = ({1'b0, dst_q} < 9'(NQ)) && live_q[dst_q[5:0]];
  assign req_ok  = {1'b0, req_q} < 7'(NQ);
  assign is_send = act_q == mqmm_pkg::ACT_SEND;
  assign is_rdq  = (act_q == mqmm_pkg::ACT_RECV) || (act_q == mqmm_pkg::ACT_PEEK);

  always_comb begin
    st = mqmm_pkg::ST_OK;
    if (is_send) begin
      priority if (len_q > 8'(mqmm_pkg::PAYLOAD_BYTES)) st = mqmm_pkg::ST_TOO_LARGE;
      else if (!dst_ok)                               st = mqmm_pkg::ST_BAD_PID;
      else if (cnt_d >= CW'(mqmm_pkg::QUEUE_LIMIT))   st = mqmm_pkg::ST_QUEUE_FULL;
      else if (free_cnt_q == '0)                      st = mqmm_pkg::ST_NO_SLOT;
      else                                            st = mqmm_pkg::ST_OK;
    end else if (is_rdq) begin
      priority if (!req_ok)       st = mqmm_pkg::ST_BAD_PID;
      else if (cnt_r == '0)       st = (act_q == mqmm_pkg::ACT_RECV)
                                       ? mqmm_pkg::ST_WOULD_BLOCK : mqmm_pkg::ST_EMPTY;
      else                        st = mqmm_pkg::ST_OK;
    end else begin
      st = mqmm_pkg::ST_BAD_PID;
    end
  end

  assign send_ok = is_send && (st == mqmm_pkg::ST_OK);
  assign read_ok = is_rdq && (st == mqmm_pkg::ST_OK);
  assign recv_ok = read_ok && (act_q == mqmm_pkg::ACT_RECV);

  // Copy length and byte masks
  assign copy = ({4'b0, s_len_q} < mlen_q) ? s_len_q : mlen_q[3:0];

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      send_mask[8*b +: 8] = {8{len_q > 8'(b)}};
      rd_data[8*b +: 8]   = (copy > 4'(b)) ? s_pay_q[8*b +: 8] : 8'h00;
    end
  end

  // Requester count after the request
  always_comb begin
    pend = cnt_r;
    if (!req_ok)                                       pend = '0;
    else if (send_ok && (dst_q[QW-1:0] == req_q[QW-1:0])) pend = cnt_r + 5'd1;
    else if (recv_ok)                                  pend = cnt_r - 5'd1;
  end

  // Free list update
  always_comb begin
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    if (cmd_i.commit && send_ok) begin
      free_head_d = fnx;
      free_cnt_d  = free_cnt_q - FW'(1);
    end else if (cmd_i.commit && recv_ok) begin
      free_head_d = head_r_q;
      free_cnt_d  = free_cnt_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_cnt_q  <= FW'(NP);
      nxt_vld_q   <= '0;
      cnt_vld_q   <= '0;
    end else begin
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      if (cmd_i.commit && send_ok && (cnt_d != '0)) nxt_vld_q[tail_d_q] <= 1'b1;
      if (cmd_i.commit && recv_ok)                  nxt_vld_q[head_r_q] <= 1'b1;
      if (cmd_i.commit && send_ok)                  cnt_vld_q[dst_q[QW-1:0]] <= 1'b1;
      if (cmd_i.commit && recv_ok)                  cnt_vld_q[req_q[QW-1:0]] <= 1'b1;
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && send_ok) begin
      pay_mem[free_head_q]        <= pay_q & send_mask;
      len_mem[free_head_q]        <= len_q[3:0];
      src_mem[free_head_q]        <= req_q;
      tail_mem[dst_q[QW-1:0]]     <= free_head_q;
      cnt_mem[dst_q[QW-1:0]]      <= cnt_d + CW'(1);
      if (cnt_d == '0) head_mem[dst_q[QW-1:0]] <= free_head_q;
      else             nxt_mem[tail_d_q]       <= free_head_q;
    end else if (cmd_i.commit && recv_ok) begin
      head_mem[req_q[QW-1:0]]     <= snx;
      cnt_mem[req_q[QW-1:0]]      <= cnt_r - CW'(1);
      nxt_mem[head_r_q]           <= free_head_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= st;
      data_q    <= read_ok ? rd_data : '0;
      copy_q    <= read_ok ? copy : '0;
      source_q  <= read_ok ? s_src_q : '0;
      pending_q <= pend;
    end
  end

  assign status_o   = status_q;
  assign data_o     = data_q;
  assign xfer_len_o = copy_q;
  assign source_o   = source_q;
  assign pending_o  = pending_q;
  assign free_cnt_o = free_cnt_q;

endmodule

[src/multi_queue_mailbox_manager_core.sv]
// Multi-queue mailbox manager: one result beat per request beat.
// Steps: queue table read, slot table read at the queue head, commit; the
// commit waits while the last result beat is not taken. One request is in
// flight, since the head-then-slot memory reads and the commit are dependent.
// Reset: free list chained in slot order, all queues empty, live mask zero.
module multi_queue_mailbox_manager_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,      // live_mask
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // requester[5:0] dest[13:6] payload[77:14] length[85:78] max_len[93:86]
  input  logic [mqmm_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,   // action[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // data[63:0] xfer_len[67:64] source[73:68] pending[78:74]
  output logic [mqmm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // status[2:0]
);

  mqmm_pkg::ctrl_cmd_t          cmd;
  logic [2:0]                   status;
  logic [63:0]                  data;
  logic [3:0]                   xfer_len;
  logic [5:0]                   source;
  logic [4:0]                   pending;
  logic [mqmm_pkg::FC_W-1:0]    free_cnt;

  mqmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  mqmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (s_axis_tuser_i),
    .requester_i (s_axis_tdata_i[5:0]),
    .dest_i      (s_axis_tdata_i[13:6]),
    .payload_i   (s_axis_tdata_i[77:14]),
    .length_i    (s_axis_tdata_i[85:78]),
    .max_len_i   (s_axis_tdata_i[93:86]),
    .status_o    (status),
    .data_o      (data),
    .xfer_len_o  (xfer_len),
    .source_o    (source),
    .pending_o   (pending),
    .free_cnt_o  (free_cnt)
  );

  assign m_axis_tdata_o = {1'b0, pending, source, xfer_len, data};
  assign m_axis_tuser_o = status;

`ifndef ASSERT_OFF
  // One request in flight: ready drops right after an input beat
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input beat taken while a request is in flight");

  // Free slot count never exceeds the pool
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt <= mqmm_pkg::FC_W'(mqmm_pkg::POOL_SLOTS))
    else $error("free slot count above pool size");

  // Free count changes only at a commit
  a_free_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.commit |=> $stable(free_cnt))
    else $error("free slot count changed outside commit");

  // Delivered copy length never exceeds the payload width
  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (xfer_len <= 4'(mqmm_pkg::PAYLOAD_BYTES)))
    else $error("copy length above payload width");
`endif

endmodule
